### rtl/core/cfb_pkg.sv
// Shared types, constants and functions for the command frame builder.
// Holds the queue entry format, the back end phases and the CRC-16 step.
// No dependencies.
package cfb_pkg;

    localparam int unsigned MAX_PAYLOAD = 14;
    localparam int unsigned QDEPTH      = 4;
    localparam int unsigned QPTR_W      = $clog2(QDEPTH);
    localparam int unsigned QCNT_W      = $clog2(QDEPTH + 1);

    localparam logic [7:0]  STX_HIGH  = 8'h55;
    localparam logic [7:0]  STX_LOW   = 8'h66;
    localparam logic [7:0]  CTRL_ACK  = 8'h01;
    localparam logic [15:0] CRC_POLY  = 16'h1021;
    localparam logic [15:0] HIGH_MASK = 16'hFF00;

    localparam logic        KIND_START   = 1'b0;
    localparam logic        KIND_PAYLOAD = 1'b1;

    localparam logic [2:0]  HDR_STX_LOW = 3'd1;
    localparam logic [2:0]  HDR_CTRL    = 3'd2;
    localparam logic [2:0]  HDR_LEN_LO  = 3'd3;
    localparam logic [2:0]  HDR_LEN_HI  = 3'd4;
    localparam logic [2:0]  HDR_SEQ_LO  = 3'd5;
    localparam logic [2:0]  HDR_SEQ_HI  = 3'd6;
    localparam logic [2:0]  HDR_CMD     = 3'd7;

    typedef enum logic {
        OP_START,
        OP_DATA
    } t_op;

    typedef struct packed {
        t_op         op;
        logic [7:0]  cmd_id;
        logic [3:0]  len;
        logic [15:0] seq;
        logic [7:0]  data;
        logic        last;
    } t_cmd;

    typedef struct packed {
        logic empty;
        logic full;
    } t_q_status;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_HDR,
        PH_CRC_LO,
        PH_CRC_HI
    } t_phase;

    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int i = 0; i < 8; i++) begin
            if (c[15]) begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

    function automatic logic [7:0] hdr_byte(input logic [2:0] idx, input logic [3:0] len,
                                            input logic [15:0] seq, input logic [7:0] cmd);
        logic [7:0] b;
        unique case (idx)
            HDR_STX_LOW: b = STX_LOW;
            HDR_CTRL:    b = CTRL_ACK;
            HDR_LEN_LO:  b = {4'h0, len};
            HDR_LEN_HI:  b = 8'h00;
            HDR_SEQ_LO:  b = seq[7:0];
            HDR_SEQ_HI:  b = 8'((seq & HIGH_MASK) >> 8);
            HDR_CMD:     b = cmd;
            default:     b = STX_HIGH;
        endcase
        return b;
    endfunction

endpackage

### rtl/core/command_frame_builder_crc16.sv
// Top level of the command frame builder with CRC-16/XMODEM.
// Connects cfb_front, cfb_queue and cfb_back. Depends on cfb_pkg.
//
// The block emits one frame byte per cycle on its output channel while it has bytes to send
// and the sink takes them. A legal start item produces an 8-byte header, plus both CRC bytes
// when its length is zero; a payload byte produces one output byte, followed by both CRC
// bytes when it closes the frame. Input items are accepted one per cycle as long as the
// four-entry command queue between the front and back ends has room, and illegal items are
// accepted and dropped without using a slot. The sustained rate is set by the single output
// byte register, one byte per cycle while the sink takes them.
module command_frame_builder_crc16 import cfb_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic       i_kind,
    input  logic [7:0] i_cmd_id,
    input  logic [3:0] i_payload_len,
    input  logic [7:0] i_payload_byte,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_frame_byte,
    output logic       o_frame_last
);

    t_cmd      w_push_cmd;
    t_cmd      w_head;
    t_q_status w_q_status;
    logic      w_push;
    logic      w_pop;

    cfb_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_kind         (i_kind),
        .i_cmd_id       (i_cmd_id),
        .i_payload_len  (i_payload_len),
        .i_payload_byte (i_payload_byte),
        .i_q_status     (w_q_status),
        .o_push         (w_push),
        .o_cmd          (w_push_cmd)
    );

    cfb_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_cmd    (w_push_cmd),
        .i_pop    (w_pop),
        .o_head   (w_head),
        .o_status (w_q_status)
    );

    cfb_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head       (w_head),
        .i_q_status   (w_q_status),
        .o_pop        (w_pop),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_frame_byte (o_frame_byte),
        .o_frame_last (o_frame_last)
    );

    a_push_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |=> !w_q_status.empty)
        else $error("Queue empty right after a push.");

    a_legal_start_pushes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready && i_kind == KIND_START && 32'(i_payload_len) <= MAX_PAYLOAD)
        |-> w_push)
        else $error("Legal start item was not queued.");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("Output valid right after reset.");

    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> !w_q_status.empty)
        else $error("Pop from an empty queue.");

endmodule

### rtl/core/cfb_front.sv
// Front end: accepts input items, drops illegal ones, tracks the open frame.
// Pushes start and payload commands into the queue. Depends on cfb_pkg.
module cfb_front import cfb_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_kind,
    input  logic [7:0]  i_cmd_id,
    input  logic [3:0]  i_payload_len,
    input  logic [7:0]  i_payload_byte,
    input  t_q_status   i_q_status,
    output logic        o_push,
    output t_cmd        o_cmd
);

    logic [15:0] r_seq, n_seq;
    logic [3:0]  r_remain, n_remain;
    logic        r_open, n_open;
    logic        w_accept;

    assign o_ready  = !i_q_status.full;
    assign w_accept = i_valid && o_ready;

    always_comb begin
        n_seq    = r_seq;
        n_remain = r_remain;
        n_open   = r_open;
        o_push   = 1'b0;
        o_cmd.op     = (i_kind == KIND_START) ? OP_START : OP_DATA;
        o_cmd.cmd_id = i_cmd_id;
        o_cmd.len    = i_payload_len;
        o_cmd.seq    = r_seq;
        o_cmd.data   = i_payload_byte;
        o_cmd.last   = (r_remain == 4'd1);
        if (w_accept) begin
            if (i_kind == KIND_START) begin
                if (32'(i_payload_len) <= MAX_PAYLOAD) begin
                    o_push   = 1'b1;
                    n_seq    = r_seq + 16'd1;
                    n_open   = (i_payload_len != 4'd0);
                    n_remain = i_payload_len;
                end
            end else if (r_open) begin
                o_push   = 1'b1;
                n_remain = r_remain - 4'd1;
                n_open   = (r_remain != 4'd1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seq    <= '0;
            r_remain <= '0;
            r_open   <= 1'b0;
        end else begin
            r_seq    <= n_seq;
            r_remain <= n_remain;
            r_open   <= n_open;
        end
    end

endmodule

### rtl/core/cfb_queue.sv
// Short command queue between the front and back ends.
// Register array with read and write pointers. Depends on cfb_pkg.
module cfb_queue import cfb_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_cmd      i_cmd,
    input  logic      i_pop,
    output t_cmd      o_head,
    output t_q_status o_status
);

    t_cmd              r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wr, r_rd;
    logic [QCNT_W-1:0] r_cnt;
    logic              w_push, w_pop;

    assign o_status.empty = (r_cnt == '0);
    assign o_status.full  = (r_cnt == QCNT_W'(QDEPTH));
    assign w_push = i_push && !o_status.full;
    assign w_pop  = i_pop && !o_status.empty;
    assign o_head = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wr <= r_wr + QPTR_W'(1);
            end
            if (w_pop) begin
                r_rd <= r_rd + QPTR_W'(1);
            end
            r_cnt <= r_cnt + QCNT_W'(w_push) - QCNT_W'(w_pop);
        end
    end

endmodule

### rtl/core/cfb_back.sv
// Back end: turns queued commands into frame bytes and appends the CRC.
// Drives the registered output channel. Depends on cfb_pkg.
module cfb_back import cfb_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cmd       i_head,
    input  t_q_status  i_q_status,
    output logic       o_pop,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_frame_byte,
    output logic       o_frame_last
);

    t_phase      r_phase, n_phase;
    logic [2:0]  r_idx, n_idx;
    logic [15:0] r_crc, n_crc;
    logic [3:0]  r_len, n_len;
    logic [15:0] r_seq, n_seq;
    logic [7:0]  r_cmd, n_cmd;
    logic        r_valid, n_valid;
    logic [7:0]  r_byte, n_byte;
    logic        r_last, n_last;
    logic        w_free;
    logic [7:0]  w_hdr;

    assign w_free       = !r_valid || i_ready;
    assign w_hdr        = hdr_byte(r_idx, r_len, r_seq, r_cmd);
    assign o_valid      = r_valid;
    assign o_frame_byte = r_byte;
    assign o_frame_last = r_last;

    always_comb begin
        n_phase = r_phase;
        n_idx   = r_idx;
        n_crc   = r_crc;
        n_len   = r_len;
        n_seq   = r_seq;
        n_cmd   = r_cmd;
        n_valid = r_valid;
        n_byte  = r_byte;
        n_last  = r_last;
        o_pop   = 1'b0;
        if (w_free) begin
            n_valid = 1'b0;
            n_last  = 1'b0;
            unique case (r_phase)
                PH_IDLE: begin
                    if (!i_q_status.empty) begin
                        o_pop   = 1'b1;
                        n_valid = 1'b1;
                        if (i_head.op == OP_START) begin
                            n_byte  = STX_HIGH;
                            n_crc   = crc_byte(16'h0000, STX_HIGH);
                            n_idx   = HDR_STX_LOW;
                            n_len   = i_head.len;
                            n_seq   = i_head.seq;
                            n_cmd   = i_head.cmd_id;
                            n_phase = PH_HDR;
                        end else begin
                            n_byte = i_head.data;
                            n_crc  = crc_byte(r_crc, i_head.data);
                            if (i_head.last) begin
                                n_phase = PH_CRC_LO;
                            end
                        end
                    end
                end
                PH_HDR: begin
                    n_valid = 1'b1;
                    n_byte  = w_hdr;
                    n_crc   = crc_byte(r_crc, w_hdr);
                    n_idx   = r_idx + 3'd1;
                    if (r_idx == HDR_CMD) begin
                        n_phase = (r_len == 4'd0) ? PH_CRC_LO : PH_IDLE;
                    end
                end
                PH_CRC_LO: begin
                    n_valid = 1'b1;
                    n_byte  = r_crc[7:0];
                    n_phase = PH_CRC_HI;
                end
                PH_CRC_HI: begin
                    n_valid = 1'b1;
                    n_byte  = 8'((r_crc & HIGH_MASK) >> 8);
                    n_last  = 1'b1;
                    n_phase = PH_IDLE;
                end
                default: n_phase = PH_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_idx   <= '0;
            r_crc   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_idx   <= n_idx;
            r_crc   <= n_crc;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_len  <= n_len;
        r_seq  <= n_seq;
        r_cmd  <= n_cmd;
        r_byte <= n_byte;
        r_last <= n_last;
    end

endmodule
